/* hw/rtl/sbt_pkg.sv */
`timescale 1ns / 1ps

package sbt_pkg;

  localparam int SCREEN_W_DEF = 320;
  localparam int SCREEN_H_DEF = 200;

  // Enough bits for origin + row * width + column at the largest screen size.
  localparam int OFF_W = 29;

  localparam int QUEUE_DEPTH = 2;

  localparam int DEST_X_W = 9;
  localparam int DEST_Y_W = 8;
  localparam int CFG_DATA_W = 9;

  localparam logic CFG_DEST_X = 1'b0;
  localparam logic CFG_DEST_Y = 1'b1;

  typedef struct packed {
    logic             is_pixel;
    logic [OFF_W-1:0] offset;
    logic [7:0]       color;
    logic             done;
  } sbt_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sbt_queue_status_t;

endpackage

/* hw/rtl/sbt_front.sv */
`timescale 1ns / 1ps

module sbt_front #(
  parameter int SCREEN_W = sbt_pkg::SCREEN_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [sbt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          accept,
  input  logic [7:0]                    sprite_byte,
  output sbt_pkg::sbt_item_t            item
);

  localparam int OFF_W = sbt_pkg::OFF_W;

  typedef enum logic [2:0] {
    HDR_W_LO,
    HDR_W_HI,
    HDR_H_LO,
    HDR_H_HI,
    PIXELS
  } hdr_state_t;

  hdr_state_t                    state_r;
  logic [sbt_pkg::DEST_X_W-1:0]  dest_x_r;
  logic [sbt_pkg::DEST_Y_W-1:0]  dest_y_r;
  logic [15:0]                   width_r;
  logic [15:0]                   height_r;
  logic [15:0]                   col_r;
  logic [15:0]                   row_r;
  logic [OFF_W-1:0]              row_base_r;

  logic [15:0]      height_full;
  logic             col_last;
  logic             row_last;
  logic             zero_size;
  logic [OFF_W-1:0] origin;

  assign height_full = {sprite_byte, height_r[7:0]};
  assign col_last    = (col_r + 16'd1) == width_r;
  assign row_last    = (row_r + 16'd1) == height_r;
  assign zero_size   = (width_r == 16'd0) || (height_full == 16'd0);
  assign origin      = OFF_W'(dest_y_r) * OFF_W'(SCREEN_W) + OFF_W'(dest_x_r);

  always_comb begin
    item.is_pixel = (state_r == PIXELS);
    item.offset   = row_base_r + OFF_W'(col_r);
    item.color    = sprite_byte;
    if (state_r == PIXELS) begin
      item.done = col_last && row_last;
    end else begin
      item.done = (state_r == HDR_H_HI) && zero_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= HDR_W_LO;
      dest_x_r <= '0;
      dest_y_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sbt_pkg::CFG_DEST_X: dest_x_r <= cfg_data[sbt_pkg::DEST_X_W-1:0];
          sbt_pkg::CFG_DEST_Y: dest_y_r <= cfg_data[sbt_pkg::DEST_Y_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        case (state_r)
          HDR_W_LO: begin
            width_r <= {8'd0, sprite_byte};
            state_r <= HDR_W_HI;
          end
          HDR_W_HI: begin
            width_r[15:8] <= sprite_byte;
            state_r       <= HDR_H_LO;
          end
          HDR_H_LO: begin
            height_r <= {8'd0, sprite_byte};
            state_r  <= HDR_H_HI;
          end
          HDR_H_HI: begin
            height_r   <= height_full;
            col_r      <= '0;
            row_r      <= '0;
            row_base_r <= origin;
            state_r    <= zero_size ? HDR_W_LO : PIXELS;
          end
          PIXELS: begin
            if (col_last) begin
              col_r      <= '0;
              row_base_r <= row_base_r + OFF_W'(SCREEN_W);
              if (row_last) begin
                row_r   <= '0;
                state_r <= HDR_W_LO;
              end else begin
                row_r <= row_r + 16'd1;
              end
            end else begin
              col_r <= col_r + 16'd1;
            end
          end
          default: state_r <= HDR_W_LO;
        endcase
      end
    end
  end

endmodule

/* hw/rtl/sbt_queue.sv */
`timescale 1ns / 1ps

module sbt_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  sbt_pkg::sbt_item_t        push_item,
  input  logic                      pop,
  output sbt_pkg::sbt_item_t        pop_item,
  output sbt_pkg::sbt_queue_status_t status
);

  localparam int DEPTH = sbt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbt_pkg::sbt_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_item     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a lone write");

endmodule

/* hw/rtl/sbt_back.sv */
`timescale 1ns / 1ps

module sbt_back #(
  parameter int SCREEN_W = sbt_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = sbt_pkg::SCREEN_H_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sbt_pkg::sbt_item_t         item,
  input  sbt_pkg::sbt_queue_status_t qstat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_write_enable,
  output logic [15:0]                out_fb_address,
  output logic [7:0]                 out_pixel_color,
  output logic                       out_off_screen,
  output logic                       out_sprite_done
);

  localparam int OFF_W = sbt_pkg::OFF_W;
  localparam logic [OFF_W-1:0] FB_SIZE = OFF_W'(SCREEN_W * SCREEN_H);

  logic        valid_r;
  logic        we_r;
  logic [15:0] addr_r;
  logic [7:0]  color_r;
  logic        offs_r;
  logic        done_r;
  logic        outside;

  assign outside = item.offset >= FB_SIZE;
  assign pop     = !qstat.empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      we_r    <= item.is_pixel && (item.color != 8'd0) && !outside;
      addr_r  <= item.is_pixel ? item.offset[15:0] : 16'd0;
      color_r <= item.is_pixel ? item.color : 8'd0;
      offs_r  <= item.is_pixel && outside;
      done_r  <= item.done;
    end
  end

  assign out_valid        = valid_r;
  assign out_write_enable = we_r;
  assign out_fb_address   = addr_r;
  assign out_pixel_color  = color_r;
  assign out_off_screen   = offs_r;
  assign out_sprite_done  = done_r;

endmodule

/* hw/rtl/sprite_blit_transparent.sv */
`timescale 1ns / 1ps
// A byte transferred at a clock edge is written into the queue, then popped into the
// output register, whose contents drive out_valid and the result outputs.
// Throughput: one byte per cycle while in_stall is low, header and pixel bytes alike,
// set by the two-entry queue between the header parser and the output register.
// Reset (rst_n low at a clock edge): queue and output emptied, parser awaits a header,
// dest_x and dest_y cleared to zero.

module sprite_blit_transparent #(
  parameter int SCREEN_W = sbt_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = sbt_pkg::SCREEN_H_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [sbt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_sprite_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_write_enable,
  output logic [15:0]                    out_fb_address,
  output logic [7:0]                     out_pixel_color,
  output logic                           out_off_screen,
  output logic                           out_sprite_done
);

  sbt_pkg::sbt_item_t         front_item;
  sbt_pkg::sbt_item_t         queue_item;
  sbt_pkg::sbt_queue_status_t qstat;
  logic                       accept;
  logic                       pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;
  assign accept    = in_valid && !in_stall;

  sbt_front #(
    .SCREEN_W(SCREEN_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .sprite_byte(in_sprite_byte),
    .item       (front_item)
  );

  sbt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_item(front_item),
    .pop      (pop),
    .pop_item (queue_item),
    .status   (qstat)
  );

  sbt_back #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item            (queue_item),
    .qstat           (qstat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_write_enable(out_write_enable),
    .out_fb_address  (out_fb_address),
    .out_pixel_color (out_pixel_color),
    .out_off_screen  (out_off_screen),
    .out_sprite_done (out_sprite_done)
  );

endmodule

/* test/tb_sprite_blit_transparent.sv */
`timescale 1ns / 1ps

module tb_sprite_blit_transparent;

  localparam int SCR_W = sbt_pkg::SCREEN_W_DEF;
  localparam int SCR_H = sbt_pkg::SCREEN_H_DEF;
  localparam int LONG_HOLD = 60;
  localparam int RANDOM_ITEMS = 750;

  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [7:0]  color;
    logic        offs;
    logic        done;
  } blit_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = sbt_pkg::CFG_DEST_X;
  logic [sbt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_sprite_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_write_enable;
  logic [15:0] out_fb_address;
  logic [7:0] out_pixel_color;
  logic out_off_screen;
  logic out_sprite_done;

  // Shadow of the blitter state.
  logic [2:0]  hdr_pos = '0;
  logic [15:0] spr_w = '0;
  logic [15:0] spr_h = '0;
  logic [15:0] col_pos = '0;
  logic [15:0] row_pos = '0;
  logic [24:0] origin_off = '0;
  logic [8:0]  dest_x_q = '0;
  logic [7:0]  dest_y_q = '0;

  blit_result_t pending_writes[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;

  sprite_blit_transparent dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sprite_byte(in_sprite_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_write_enable(out_write_enable),
    .out_fb_address(out_fb_address),
    .out_pixel_color(out_pixel_color),
    .out_off_screen(out_off_screen),
    .out_sprite_done(out_sprite_done)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void predict_blit_result(input logic [7:0] b);
    blit_result_t r;
    longint unsigned off;
    longint unsigned row_l;
    longint unsigned col_l;
    r = '0;
    if (hdr_pos < 3'd4) begin
      case (hdr_pos)
        3'd0: spr_w = {8'h00, b};
        3'd1: spr_w[15:8] = b;
        3'd2: spr_h = {8'h00, b};
        default: spr_h[15:8] = b;
      endcase
      if (hdr_pos == 3'd3) begin
        col_pos = '0;
        row_pos = '0;
        origin_off = 25'(int'(dest_y_q) * SCR_W + int'(dest_x_q));
        if (spr_w == 16'd0 || spr_h == 16'd0) begin
          r.done = 1'b1;
          hdr_pos = 3'd0;
        end else begin
          hdr_pos = 3'd4;
        end
      end else begin
        hdr_pos = hdr_pos + 3'd1;
      end
    end else begin
      row_l = row_pos;
      col_l = col_pos;
      off = longint'(origin_off) + row_l * SCR_W + col_l;
      r.offs = (off >= SCR_W * SCR_H);
      r.addr = off[15:0];
      r.color = b;
      r.we = (b != 8'h00) && !r.offs;
      col_pos = col_pos + 16'd1;
      if (col_pos >= spr_w) begin
        col_pos = '0;
        row_pos = row_pos + 16'd1;
        if (row_pos >= spr_h) begin
          row_pos = '0;
          hdr_pos = 3'd0;
          r.done = 1'b1;
        end
      end
    end
    pending_writes.push_back(r);
  endfunction

  function automatic logic [7:0] rand_pixel();
    if ($urandom_range(0, 3) == 0) begin
      return 8'h00;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_sprite_byte <= b;
    predict_blit_result(b);
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_rest();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic send_header(input logic [15:0] w, input logic [15:0] h);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
    send_byte(h[7:0]);
    send_byte(h[15:8]);
  endtask

  task automatic send_sprite(input logic [15:0] w, input logic [15:0] h);
    send_header(w, h);
    repeat (int'(w) * int'(h)) send_byte(rand_pixel());
  endtask

  // Registers change only once the block has delivered every pending result.
  task automatic set_dest(input logic [8:0] x, input logic [7:0] y);
    sender_rest();
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= sbt_pkg::CFG_DEST_X;
    cfg_data <= x;
    do @(posedge clk); while (!cfg_ready);
    dest_x_q = x;
    cfg_index <= sbt_pkg::CFG_DEST_Y;
    cfg_data <= {1'b0, y};
    do @(posedge clk); while (!cfg_ready);
    dest_y_q = y;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_zero_size_headers();
    set_dest(9'd0, 8'd0);
    send_header(16'h0000, 16'h0005);
    send_header(16'hFFFF, 16'h0000);
  endtask

  task automatic test_screen_edge_pixels();
    set_dest(9'd318, 8'd199);
    send_header(16'd2, 16'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
  endtask

  task automatic test_far_origin();
    set_dest(9'h1FF, 8'hFF);
    send_header(16'd1, 16'd2);
    send_byte(8'hAA);
    send_byte(8'h55);
  endtask

  task automatic test_config_mid_sprite();
    set_dest(9'd10, 8'd0);
    send_header(16'd2, 16'd1);
    send_byte(8'h11);
    set_dest(9'd100, 8'd5);
    send_byte(8'h22);
    send_sprite(16'd1, 16'd1);
  endtask

  task automatic test_backpressure();
    set_dest(9'($urandom_range(0, 319)), 8'($urandom_range(0, 199)));
    gaps_on = 1'b0;
    hold_requests++;
    send_sprite(16'd4, 16'd4);
    sender_rest();
    wait_drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_wide_sprite();
    set_dest(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
    send_sprite(16'($urandom_range(321, 340)), 16'd1);
  endtask

  task automatic test_random_sprites();
    int goal;
    int kind;
    logic [15:0] w;
    logic [15:0] h;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      case ($urandom_range(0, 5))
        0: set_dest(9'd0, 8'd0);
        1: set_dest(9'h1FF, 8'hFF);
        2: set_dest(9'd319, 8'd199);
        3: set_dest(9'($urandom_range(0, 511)), 8'($urandom_range(180, 255)));
        default: set_dest(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 8)) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            w = 16'd0;
            h = 16'($urandom_range(0, 65535));
          end else begin
            w = 16'($urandom_range(0, 65535));
            h = 16'd0;
          end
        end else if (kind == 1) begin
          w = 16'd1;
          h = 16'($urandom_range(8, 24));
        end else begin
          w = 16'($urandom_range(1, 10));
          h = 16'($urandom_range(1, 6));
        end
        send_sprite(w, h);
      end
    end
  endtask

  initial begin : rx_stall_pattern
    int hold_left;
    int mode_left;
    stall_mode_t mode;
    hold_left = 0;
    mode_left = 0;
    mode = STALL_NONE;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    blit_result_t got;
    blit_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_write_enable, out_fb_address, out_pixel_color, out_off_screen,
             out_sprite_done};
      if (pending_writes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: unexpected result we=%0b addr=%0d color=%0d off=%0b done=%0b",
                   $realtime, got.we, got.addr, got.color, got.offs, got.done);
        end
      end else begin
        want = pending_writes.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display(
              "%0t: exp/got we %0b/%0b addr %0d/%0d color %0d/%0d off %0b/%0b done %0b/%0b",
              $realtime, want.we, got.we, want.addr, got.addr, want.color, got.color,
              want.offs, got.offs, want.done, got.done);
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_size_headers();
    test_screen_edge_pixels();
    test_far_origin();
    test_config_mid_sprite();
    test_backpressure();
    test_wide_sprite();
    test_random_sprites();
    sender_rest();
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/sbt_pkg.sv
hw/rtl/sbt_front.sv
hw/rtl/sbt_queue.sv
hw/rtl/sbt_back.sv
hw/rtl/sprite_blit_transparent.sv
test/tb_sprite_blit_transparent.sv
